FILE: src/bpa_pkg.sv
package bpa_pkg;

	localparam int PAGES     = 1024;
	localparam int MAX_ORDER = 10;

	localparam int CMD_W = 2;
	localparam int IDX_W = $clog2(PAGES);
	localparam int CNT_W = IDX_W + 1;
	localparam int ST_W  = 2;

	localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_INIT   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_NO_SPACE = 2'd1;
	localparam logic [ST_W-1:0] ST_BAD      = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [IDX_W-1:0] page_index;
		logic [CNT_W-1:0] request_pages;
	} cmd_item_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [IDX_W-1:0] block_start;
		logic [CNT_W-1:0] block_pages;
		logic [CNT_W-1:0] pages_left;
	} res_item_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_CLEAR,
		OP_INIT_START,
		OP_CARVE,
		OP_INIT_DONE,
		OP_ALLOC_START,
		OP_SEARCH_NEXT,
		OP_SPLIT_TOP,
		OP_SPLIT,
		OP_ALLOC_OK,
		OP_FREE_START,
		OP_CLASH1,
		OP_CLASH1_LAST,
		OP_CLASH2,
		OP_MERGE_START,
		OP_MERGE_STEP,
		OP_FREE_OK,
		OP_FAIL,
		OP_PUBLISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t          op;
		logic            rd_buddy;
		logic [ST_W-1:0] fail_code;
	} dp_cmd_t;

	typedef struct packed {
		logic is_init;
		logic is_alloc;
		logic is_free;
		logic bad;
		logic no_room;
		logic misfit;
		logic rd_bit;
		logic scan_wrap;
		logic order_top;
		logic order_k;
		logic k_zero;
		logic c2_wrap;
		logic c2_last;
		logic rem_zero;
		logic clr_last;
		logic clash;
	} dp_stat_t;

endpackage

FILE: src/bpa_datapath.sv
module bpa_datapath
	import bpa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_item_t cmd_item,
	input  logic      cfg_valid,
	input  logic [CNT_W-1:0] cfg_data,
	input  dp_cmd_t   dp_cmd,
	output dp_stat_t  dp_stat,
	output res_item_t res_item
);

	localparam int PW = ($clog2(PAGES) + 1 > CNT_W) ? $clog2(PAGES) + 1 : CNT_W;
	localparam int MW = $clog2(2 * PAGES);
	localparam int OW = $clog2(MAX_ORDER + 1);
	localparam int DEPTH = 2 * PAGES;
	localparam logic [31:0] TWO_P = 32'(2 * PAGES);
	localparam logic [PW-1:0] PAGES_W = PW'(PAGES);
	localparam logic [OW-1:0] TOP_ORDER = OW'(MAX_ORDER);

	// Bitmap of order k starts after the maps of all smaller orders.
	function automatic logic [MW-1:0] map_index(input logic [OW-1:0] order,
		input logic [PW-1:0] addr);
		logic [31:0] sum;
		sum = TWO_P - (TWO_P >> order) + (32'(addr) >> order);
		return sum[MW-1:0];
	endfunction

	logic [CNT_W-1:0] pool_q;
	logic [CMD_W-1:0] cmd_q;
	logic [PW-1:0]    idx_q, r_q, a_q, rem_q, free_q;
	logic [OW-1:0]    k_q, j_q;
	logic             bad_q, clash_q, rd_q;
	logic [MW-1:0]    clr_q;
	res_item_t        wres_q, out_q;

	logic mem [DEPTH];

	logic [OW-1:0] k_rnd, jc, jm1, j_nx;
	logic [PW-1:0] r_rnd, req_ext, step, a_nx, n_init, step_c, step_m1;
	logic          we, wd;
	logic [MW-1:0] wa, ra;

	always_comb begin
		req_ext = PW'(cmd_item.request_pages);
		k_rnd = TOP_ORDER;
		for (int i = MAX_ORDER; i >= 0; i--) begin
			if ((PW'(1) << i) >= req_ext)
				k_rnd = OW'(i);
		end
		r_rnd = PW'(1) << k_rnd;
	end

	always_comb begin
		jc = '0;
		for (int i = 0; i <= MAX_ORDER; i++) begin
			if ((PW'(1) << i) <= rem_q && (a_q & ((PW'(1) << i) - PW'(1))) == '0)
				jc = OW'(i);
		end
	end

	assign step    = PW'(1) << j_q;
	assign a_nx    = a_q + step;
	assign jm1     = j_q - OW'(1);
	assign j_nx    = j_q + OW'(1);
	assign step_c  = PW'(1) << jc;
	assign step_m1 = PW'(1) << jm1;
	assign n_init  = (PW'(pool_q) > PAGES_W) ? PAGES_W : PW'(pool_q);

	always_comb begin
		we = 1'b0;
		wd = 1'b0;
		wa = map_index(j_q, a_q);
		case (dp_cmd.op)
			OP_CLEAR: begin
				we = 1'b1;
				wa = clr_q;
			end
			OP_CARVE: begin
				we = 1'b1;
				wd = 1'b1;
				wa = map_index(jc, a_q);
			end
			OP_SPLIT_TOP: we = 1'b1;
			OP_SPLIT: begin
				we = 1'b1;
				wd = 1'b1;
				wa = map_index(jm1, a_q + step_m1);
			end
			OP_MERGE_STEP: begin
				we = 1'b1;
				wa = map_index(j_q, a_q ^ step);
			end
			OP_FREE_OK: begin
				we = 1'b1;
				wd = 1'b1;
			end
			default: we = 1'b0;
		endcase
		ra = dp_cmd.rd_buddy ? map_index(j_q, a_q ^ step) : map_index(j_q, a_q);
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= CNT_W'(1024);
			free_q <= '0;
			clr_q  <= '0;
		end else begin
			if (cfg_valid)
				pool_q <= cfg_data;
			case (dp_cmd.op)
				OP_CLEAR:      clr_q <= clr_q + MW'(1);
				OP_INIT_START: free_q <= n_init;
				OP_ALLOC_OK:   free_q <= free_q - r_q;
				OP_FREE_OK:    free_q <= free_q + r_q;
				default:       free_q <= free_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (dp_cmd.op)
			OP_LOAD: begin
				cmd_q   <= cmd_item.command;
				idx_q   <= PW'(cmd_item.page_index);
				r_q     <= r_rnd;
				k_q     <= k_rnd;
				bad_q   <= (req_ext == '0) || (req_ext > PAGES_W);
				clash_q <= 1'b0;
			end
			OP_INIT_START: begin
				rem_q <= n_init;
				a_q   <= '0;
			end
			OP_CARVE: begin
				a_q   <= a_q + step_c;
				rem_q <= rem_q - step_c;
			end
			OP_INIT_DONE: wres_q <= '{ST_OK, '0, CNT_W'(free_q), CNT_W'(free_q)};
			OP_ALLOC_START: begin
				j_q <= k_q;
				a_q <= '0;
			end
			OP_SEARCH_NEXT: begin
				if (a_nx >= PAGES_W) begin
					j_q <= j_nx;
					a_q <= '0;
				end else begin
					a_q <= a_nx;
				end
			end
			OP_SPLIT: j_q <= jm1;
			OP_ALLOC_OK: wres_q <= '{ST_OK, a_q[IDX_W-1:0], CNT_W'(r_q),
				CNT_W'(free_q - r_q)};
			OP_FREE_START: begin
				j_q <= k_q;
				a_q <= idx_q;
			end
			OP_CLASH1: begin
				clash_q <= clash_q | rd_q;
				j_q     <= j_nx;
				a_q     <= idx_q & ~((PW'(1) << j_nx) - PW'(1));
			end
			OP_CLASH1_LAST: begin
				clash_q <= clash_q | rd_q;
				j_q     <= '0;
				a_q     <= idx_q;
			end
			OP_CLASH2: begin
				clash_q <= clash_q | rd_q;
				if (a_nx >= idx_q + r_q) begin
					j_q <= j_nx;
					a_q <= idx_q;
				end else begin
					a_q <= a_nx;
				end
			end
			OP_MERGE_START: begin
				j_q <= k_q;
				a_q <= idx_q;
			end
			OP_MERGE_STEP: begin
				a_q <= a_q & ~step;
				j_q <= j_nx;
			end
			OP_FREE_OK: wres_q <= '{ST_OK, idx_q[IDX_W-1:0], CNT_W'(r_q),
				CNT_W'(free_q + r_q)};
			OP_FAIL: wres_q <= '{dp_cmd.fail_code, '0, '0, CNT_W'(free_q)};
			OP_PUBLISH: out_q <= wres_q;
			default: a_q <= a_q;
		endcase
	end

	always_comb begin
		dp_stat.is_init   = (cmd_q == CMD_INIT);
		dp_stat.is_alloc  = (cmd_q == CMD_ALLOC);
		dp_stat.is_free   = (cmd_q == CMD_FREE);
		dp_stat.bad       = bad_q;
		dp_stat.no_room   = (r_q > free_q);
		dp_stat.misfit    = ((idx_q & (r_q - PW'(1))) != '0) || (idx_q + r_q > PAGES_W);
		dp_stat.rd_bit    = rd_q;
		dp_stat.scan_wrap = (a_nx >= PAGES_W);
		dp_stat.order_top = (j_q == TOP_ORDER);
		dp_stat.order_k   = (j_q == k_q);
		dp_stat.k_zero    = (k_q == '0);
		dp_stat.c2_wrap   = (a_nx >= idx_q + r_q);
		dp_stat.c2_last   = (j_q == k_q - OW'(1));
		dp_stat.rem_zero  = (rem_q == '0);
		dp_stat.clr_last  = (clr_q == MW'(DEPTH - 1));
		dp_stat.clash     = clash_q;
	end

	assign res_item = out_q;

endmodule

FILE: src/bpa_ctrl.sv
module bpa_ctrl
	import bpa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_ready,
	output logic     res_valid,
	input  logic     res_ready,
	input  dp_stat_t dp_stat,
	output dp_cmd_t  dp_cmd
);

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_DEC, S_ICLR, S_ISTART, S_CARVE,
		S_SRD, S_SCHK, S_SPLIT,
		S_C1RD, S_C1CHK, S_C2RD, S_C2CHK, S_CDEC,
		S_MRD, S_MCHK, S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   res_valid_q;

	always_comb begin
		state_d = state_q;
		dp_cmd  = '{OP_NONE, 1'b0, ST_BAD};
		case (state_q)
			S_CLR: begin
				dp_cmd.op = OP_CLEAR;
				if (dp_stat.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (cmd_valid) begin
					dp_cmd.op = OP_LOAD;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (dp_stat.is_init) begin
					state_d = S_ICLR;
				end else if (!(dp_stat.is_alloc || dp_stat.is_free) || dp_stat.bad) begin
					dp_cmd.op = OP_FAIL;
					state_d = S_DONE;
				end else if (dp_stat.is_alloc) begin
					if (dp_stat.no_room) begin
						dp_cmd = '{OP_FAIL, 1'b0, ST_NO_SPACE};
						state_d = S_DONE;
					end else begin
						dp_cmd.op = OP_ALLOC_START;
						state_d = S_SRD;
					end
				end else if (dp_stat.misfit) begin
					dp_cmd.op = OP_FAIL;
					state_d = S_DONE;
				end else begin
					dp_cmd.op = OP_FREE_START;
					state_d = S_C1RD;
				end
			end
			S_ICLR: begin
				dp_cmd.op = OP_CLEAR;
				if (dp_stat.clr_last)
					state_d = S_ISTART;
			end
			S_ISTART: begin
				dp_cmd.op = OP_INIT_START;
				state_d = S_CARVE;
			end
			S_CARVE: begin
				if (dp_stat.rem_zero) begin
					dp_cmd.op = OP_INIT_DONE;
					state_d = S_DONE;
				end else begin
					dp_cmd.op = OP_CARVE;
				end
			end
			S_SRD: state_d = S_SCHK;
			S_SCHK: begin
				if (dp_stat.rd_bit) begin
					dp_cmd.op = OP_SPLIT_TOP;
					state_d = S_SPLIT;
				end else if (dp_stat.scan_wrap && dp_stat.order_top) begin
					dp_cmd = '{OP_FAIL, 1'b0, ST_NO_SPACE};
					state_d = S_DONE;
				end else begin
					dp_cmd.op = OP_SEARCH_NEXT;
					state_d = S_SRD;
				end
			end
			S_SPLIT: begin
				if (dp_stat.order_k) begin
					dp_cmd.op = OP_ALLOC_OK;
					state_d = S_DONE;
				end else begin
					dp_cmd.op = OP_SPLIT;
				end
			end
			S_C1RD: state_d = S_C1CHK;
			S_C1CHK: begin
				if (dp_stat.order_top) begin
					dp_cmd.op = OP_CLASH1_LAST;
					state_d = dp_stat.k_zero ? S_CDEC : S_C2RD;
				end else begin
					dp_cmd.op = OP_CLASH1;
					state_d = S_C1RD;
				end
			end
			S_C2RD: state_d = S_C2CHK;
			S_C2CHK: begin
				dp_cmd.op = OP_CLASH2;
				state_d = (dp_stat.c2_wrap && dp_stat.c2_last) ? S_CDEC : S_C2RD;
			end
			S_CDEC: begin
				if (dp_stat.clash) begin
					dp_cmd.op = OP_FAIL;
					state_d = S_DONE;
				end else begin
					dp_cmd.op = OP_MERGE_START;
					state_d = S_MRD;
				end
			end
			S_MRD: begin
				if (dp_stat.order_top) begin
					dp_cmd.op = OP_FREE_OK;
					state_d = S_DONE;
				end else begin
					dp_cmd.rd_buddy = 1'b1;
					state_d = S_MCHK;
				end
			end
			S_MCHK: begin
				if (dp_stat.rd_bit) begin
					dp_cmd.op = OP_MERGE_STEP;
					state_d = S_MRD;
				end else begin
					dp_cmd.op = OP_FREE_OK;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!res_valid_q || res_ready) begin
					dp_cmd.op = OP_PUBLISH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (dp_cmd.op == OP_PUBLISH)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	assign cmd_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;

endmodule

FILE: src/buddy_page_allocator.sv
// Channel | Direction | Handshake            | Payload
// cmd     | in        | cmd_valid/cmd_ready  | cmd_item (command, page_index, request_pages)
// res     | out       | res_valid/res_ready  | res_item (status, block_start, block_pages,
//         |           |                      |           pages_left)
// cfg     | in        | cfg_valid/cfg_ready  | cfg_data (pool_pages)
//
// Each map access on the single bitmap memory is a read state, then a check state.
// Alloc scans bitmap entries from order k upward, then splits the found block down to order k.
// Free of 2^k pages checks entries for overlap (MAX_ORDER+1-k at and above order k,
// 2*2^k-2 below it), then merges with free buddies level by level.
// Reset and every init clear all 2*PAGES map entries; init then carves one block a cycle.
// A finished result waits in the output register while the next command is taken; a second
// finished result holds the controller, and so the input, until that register drains.
module buddy_page_allocator
	import bpa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  cmd_item_t        cmd_item,
	output logic             res_valid,
	input  logic             res_ready,
	output res_item_t        res_item,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data
);

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	assign cfg_ready = 1'b1;

	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.dp_stat   (dp_stat),
		.dp_cmd    (dp_cmd)
	);

	bpa_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_item  (cmd_item),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.dp_cmd    (dp_cmd),
		.dp_stat   (dp_stat),
		.res_item  (res_item)
	);

`ifndef ASSERT_OFF
	// One command at a time: the transfer of a command closes the input until its result.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while busy");

	// A failed command reports no block.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.status != ST_OK |->
			res_item.block_start == '0 && res_item.block_pages == '0)
		else $error("failed command reports a block");

	// The free count never exceeds PAGES.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> 32'(res_item.pages_left) <= 32'(PAGES))
		else $error("free count above pool size");
`endif

endmodule
